FILE: sv/efs_pkg.sv
// Shared types and constants for the event filter and sort unit.
// No dependencies; imported by the controller, the datapath and the top level.
package efs_pkg;

  localparam int MAX_EVENTS = 64;
  localparam int ADDR_W     = $clog2(MAX_EVENTS);
  localparam int CNT_W      = $clog2(MAX_EVENTS + 1);

  localparam int ID_W    = 10;
  localparam int DATE_W  = 27;
  localparam int KEY_W   = 16;
  localparam int ENTRY_W = ID_W + KEY_W;

  // Configuration register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TODAY_DATE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 1'b1;

  // Filter modes
  localparam logic MODE_TODAY   = 1'b0;
  localparam logic MODE_OVERDUE = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;      // latch the incoming request
    logic rd_prev;   // read the entry just below the insert position
    logic shift;     // move the read entry up one place
    logic place;     // write the new event at the insert position
    logic fetch;     // read the entry at the emit index
    logic load;      // load the result register
    logic advance;   // step the emit index
    logic clear;     // end of run: clear count, flag and index
  } efs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hit;          // incoming event is kept and fits
    logic in_last;      // last marker of the request on the input
    logic item_last;    // latched last marker of the current event
    logic pos_zero;     // insert position has reached the bottom
    logic key_greater;  // read entry sorts after the new event
    logic out_taken;    // result register handed over this cycle
    logic final_item;   // result register holds the last result
  } efs_stat_t;

endpackage

FILE: sv/efs_ctrl.sv
// Controller state machine of the event filter and sort unit.
// Depends on efs_pkg; drives the datapath through efs_cmd_t and reads efs_stat_t.
module efs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  efs_pkg::efs_stat_t stat,
  output efs_pkg::efs_cmd_t  cmd
);
  import efs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEEK,
    S_COMPARE,
    S_FETCH,
    S_LOAD,
    S_WAIT
  } state_t;

  state_t state;
  state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.hit) begin
            state_next = S_SEEK;
          end else if (stat.in_last) begin
            state_next = S_FETCH;
          end
        end
      end
      S_SEEK: begin
        if (stat.pos_zero) begin
          cmd.place  = 1'b1;
          state_next = stat.item_last ? S_FETCH : S_IDLE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_COMPARE;
        end
      end
      S_COMPARE: begin
        if (stat.key_greater) begin
          cmd.shift  = 1'b1;
          state_next = S_SEEK;
        end else begin
          cmd.place  = 1'b1;
          state_next = stat.item_last ? S_FETCH : S_IDLE;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (stat.out_taken) begin
          if (stat.final_item) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_FETCH;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/efs_datapath.sv
// Datapath of the event filter and sort unit: config registers, filter,
// sorted store memory, insert position, emit index and result register.
// Depends on efs_pkg; controlled by efs_ctrl.
module efs_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [efs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [efs_pkg::DATE_W-1:0]  cfg_data,
  input  logic [efs_pkg::ID_W-1:0]    event_id,
  input  logic [efs_pkg::DATE_W-1:0]  event_date,
  input  logic [efs_pkg::KEY_W-1:0]   start_time,
  input  logic                        is_done,
  input  logic                        is_last,
  input  efs_pkg::efs_cmd_t           cmd,
  output efs_pkg::efs_stat_t          stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [efs_pkg::ID_W-1:0]    out_event_id,
  output logic [efs_pkg::KEY_W-1:0]   out_start_time,
  output logic                        last_result,
  output logic                        none_selected,
  output logic                        overflowed
);
  import efs_pkg::*;

  // Configuration
  logic [DATE_W-1:0] today_date;
  logic              filter_mode;

  // Run state
  logic [CNT_W-1:0]  kept_count;
  logic              overflow_flag;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] emit_idx;

  // Current event
  logic [ID_W-1:0]   cur_id;
  logic [KEY_W-1:0]  cur_key;
  logic              cur_last;

  // Sorted store
  logic [ENTRY_W-1:0] store [MAX_EVENTS];
  logic [ENTRY_W-1:0] rd_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               wr_en;

  logic selects;
  logic full;
  logic empty;
  logic emit_last;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      today_date  <= '0;
      filter_mode <= MODE_TODAY;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TODAY_DATE:  today_date  <= cfg_data;
        REG_FILTER_MODE: filter_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Filter the incoming request
  always_comb begin
    if (filter_mode == MODE_OVERDUE) begin
      selects = (event_date < today_date) && !is_done;
    end else begin
      selects = (event_date == today_date);
    end
  end

  assign full      = (kept_count == CNT_W'(MAX_EVENTS));
  assign empty     = (kept_count == '0);
  assign emit_last = ((CNT_W'(emit_idx) + CNT_W'(1)) == kept_count);

  // Latch the current event
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_id   <= event_id;
      cur_key  <= start_time;
      cur_last <= is_last;
    end
  end

  // Advance count, overflow flag, insert position and emit index
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count    <= '0;
      overflow_flag <= 1'b0;
      pos           <= '0;
      emit_idx      <= '0;
    end else begin
      if (cmd.take) begin
        pos <= kept_count[ADDR_W-1:0];
        if (selects && full) begin
          overflow_flag <= 1'b1;
        end
      end
      if (cmd.shift) begin
        pos <= pos - ADDR_W'(1);
      end
      if (cmd.place) begin
        kept_count <= kept_count + CNT_W'(1);
      end
      if (cmd.advance) begin
        emit_idx <= emit_idx + ADDR_W'(1);
      end
      if (cmd.clear) begin
        kept_count    <= '0;
        overflow_flag <= 1'b0;
        emit_idx      <= '0;
      end
    end
  end

  // Store access: one read port, one write port
  assign rd_addr = cmd.rd_prev ? (pos - ADDR_W'(1)) : emit_idx;
  assign wr_data = cmd.shift ? rd_data : {cur_id, cur_key};
  assign wr_en   = cmd.shift | cmd.place;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[pos] <= wr_data;
    end
    if (cmd.rd_prev | cmd.fetch) begin
      rd_data <= store[rd_addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_event_id   <= empty ? '0 : rd_data[ENTRY_W-1:KEY_W];
      out_start_time <= empty ? '0 : rd_data[KEY_W-1:0];
      last_result    <= empty | emit_last;
      none_selected  <= empty;
      overflowed     <= overflow_flag;
    end
  end

  // Report status
  always_comb begin
    stat.hit         = selects && !full;
    stat.in_last     = is_last;
    stat.item_last   = cur_last;
    stat.pos_zero    = (pos == '0);
    stat.key_greater = (rd_data[KEY_W-1:0] > cur_key);
    stat.out_taken   = out_valid & out_ready;
    stat.final_item  = last_result;
  end

endmodule

FILE: sv/event_filter_and_sort_unit.sv
// Event filter and sort unit, top level: instantiates controller and datapath.
// Depends on efs_pkg, efs_ctrl and efs_datapath.
//
// Events arrive one request at a time; each is kept or dropped by the filter
// mode (dated today, or overdue and not done) and a kept event is inserted into
// a 64-entry store held in start-time order, equal times in arrival order. The
// store has one read port with registered data, so each step down the store is
// a read then a compare-and-write. After the request marked last, results leave
// one at a time, each loaded only after the previous one is taken, lowest start
// time first; with nothing kept a single result with none_selected is sent.
// Kept events beyond 64 are dropped and overflowed is raised on every result
// of that list. Input is not taken while an insertion or the output of a list
// is in progress. Configuration writes take effect at once and belong between
// lists.
module event_filter_and_sort_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [efs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [efs_pkg::DATE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [efs_pkg::ID_W-1:0]      event_id,
  input  logic [efs_pkg::DATE_W-1:0]    event_date,
  input  logic [efs_pkg::KEY_W-1:0]     start_time,
  input  logic                          is_done,
  input  logic                          is_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [efs_pkg::ID_W-1:0]      out_event_id,
  output logic [efs_pkg::KEY_W-1:0]     out_start_time,
  output logic                          last_result,
  output logic                          none_selected,
  output logic                          overflowed
);
  import efs_pkg::*;

  efs_cmd_t  cmd;
  efs_stat_t stat;

  efs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  efs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .event_id       (event_id),
    .event_date     (event_date),
    .start_time     (start_time),
    .is_done        (is_done),
    .is_last        (is_last),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_id   (out_event_id),
    .out_start_time (out_start_time),
    .last_result    (last_result),
    .none_selected  (none_selected),
    .overflowed     (overflowed)
  );

endmodule

FILE: tb/tb_event_filter_and_sort_unit.sv
// Self-checking testbench for event_filter_and_sort_unit: filters event requests
// by date and mode, predicts the sorted output lists and checks every result.
// Depends on efs_pkg and the event_filter_and_sort_unit RTL.
`timescale 1ns / 100ps

module tb_event_filter_and_sort_unit;
  import efs_pkg::*;

  // An insertion can walk the whole store, so settle for that long when idle
  localparam int SETTLE_CYCLES = 2 * MAX_EVENTS + 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 40;
  localparam logic [DATE_W-1:0] DATE_MAX  = '1;
  localparam logic [DATE_W-1:0] DATE_TOP  = 27'd99991231;
  localparam logic [DATE_W-1:0] DATE_MID  = 27'd7654321;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic             last;
    logic             none;
    logic             ovf;
  } result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATE_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [ID_W-1:0]      event_id;
  logic [DATE_W-1:0]    event_date;
  logic [KEY_W-1:0]     start_time;
  logic                 is_done;
  logic                 is_last;
  logic                 out_valid;
  logic                 out_ready;
  logic [ID_W-1:0]      out_event_id;
  logic [KEY_W-1:0]     out_start_time;
  logic                 last_result;
  logic                 none_selected;
  logic                 overflowed;

  // Predictor state: register copies and the sorted store of the open list
  logic [DATE_W-1:0] model_today;
  logic              model_mode;
  entry_t            sorted_events [MAX_EVENTS];
  int                sorted_count;
  logic              dropped_any;
  result_t           pending_results [$];

  // Sender and receiver control
  int   burst_left;
  logic steady;
  logic narrow_keys;
  logic sending;
  int   ready_win;
  int   ready_style;

  // Run statistics
  int cycles;
  int errors;
  int n_requests;
  int n_results;
  int n_lists;
  int n_empty_lists;
  int n_ovf_lists;
  int n_configs;

  event_filter_and_sort_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .event_id       (event_id),
    .event_date     (event_date),
    .start_time     (start_time),
    .is_done        (is_done),
    .is_last        (is_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_id   (out_event_id),
    .out_start_time (out_start_time),
    .last_result    (last_result),
    .none_selected  (none_selected),
    .overflowed     (overflowed)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Filter one accepted request and, on the last of a list, queue the sorted results
  function automatic void file_event(logic [ID_W-1:0] id, logic [DATE_W-1:0] date,
                                     logic [KEY_W-1:0] key, logic done, logic last);
    logic    keep;
    int      pos;
    entry_t  e;
    result_t r;
    if (model_mode == MODE_TODAY)
      keep = (date == model_today);
    else
      keep = (date < model_today) && !done;
    if (keep) begin
      if (sorted_count >= MAX_EVENTS) begin
        dropped_any = 1'b1;
      end else begin
        // Insert after every entry with an equal or smaller start time
        pos = sorted_count;
        while (pos > 0 && sorted_events[pos-1].key > key) begin
          sorted_events[pos] = sorted_events[pos-1];
          pos--;
        end
        e.id  = id;
        e.key = key;
        sorted_events[pos] = e;
        sorted_count++;
      end
    end
    if (last) begin
      n_lists++;
      if (dropped_any)
        n_ovf_lists++;
      if (sorted_count == 0) begin
        r.id   = '0;
        r.key  = '0;
        r.last = 1'b1;
        r.none = 1'b1;
        r.ovf  = dropped_any;
        pending_results.push_back(r);
        n_empty_lists++;
      end else begin
        for (int k = 0; k < sorted_count; k++) begin
          r.id   = sorted_events[k].id;
          r.key  = sorted_events[k].key;
          r.last = (k + 1 == sorted_count);
          r.none = 1'b0;
          r.ovf  = dropped_any;
          pending_results.push_back(r);
        end
      end
      sorted_count = 0;
      dropped_any  = 1'b0;
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none actual id %0d start %0d",
                   $time, out_event_id, out_start_time);
      end else begin
        want = pending_results.pop_front();
        check_field("out_event_id", want.id, out_event_id);
        check_field("out_start_time", want.key, out_start_time);
        check_field("last_result", want.last, last_result);
        check_field("none_selected", want.none, none_selected);
        check_field("overflowed", want.ovf, overflowed);
      end
    end
  end

  // Stall the result side in windows of varying style
  always @(posedge clk) begin
    if (ready_win <= 0) begin
      ready_style <= $urandom_range(0, 3);
      ready_win   <= $urandom_range(16, 64);
    end else begin
      ready_win <= ready_win - 1;
    end
    case (ready_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (ready_win[1:0] != 2'b00);
    endcase
  end

  // Present one event request, hold it until taken, then maybe open a gap
  task automatic send_event(input logic [ID_W-1:0] id, input logic [DATE_W-1:0] date,
                            input logic [KEY_W-1:0] key, input logic done,
                            input logic last);
    int gap;
    in_valid   <= 1'b1;
    event_id   <= id;
    event_date <= date;
    start_time <= key;
    is_done    <= done;
    is_last    <= last;
    sending = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    file_event(id, date, key, done, last);
    n_requests++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        sending = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid, wait for every expected result, then let the block settle
  task automatic drain_results();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on consecutive edges; call only when the block is idle
  task automatic set_config(input logic [DATE_W-1:0] today, input logic [DATE_W-1:0] mode_raw);
    cfg_write <= 1'b1;
    cfg_index <= REG_TODAY_DATE;
    cfg_data  <= today;
    @(posedge clk);
    model_today = today;
    cfg_index <= REG_FILTER_MODE;
    cfg_data  <= mode_raw;
    @(posedge clk);
    model_mode = mode_raw[0];
    cfg_write <= 1'b0;
    n_configs++;
  endtask

  // Bias dates towards the ones the filter cares about
  function automatic logic [DATE_W-1:0] pick_date();
    case ($urandom_range(0, 7))
      0, 1, 2: return model_today;
      3: return model_today - 1'b1;
      4: return (model_today == 0) ? '0 : DATE_W'($urandom_range(0, model_today - 1));
      5: return model_today + 1'b1;
      6: return DATE_W'($urandom);
      default: return '0;
    endcase
  endfunction

  task automatic send_random(input logic last);
    logic [KEY_W-1:0] key;
    key = narrow_keys ? KEY_W'($urandom_range(0, 7)) : KEY_W'($urandom);
    send_event(ID_W'($urandom), pick_date(), key, 1'($urandom_range(0, 1)), last);
  endtask

  // Field extremes, both modes, stable ties, empty lists and mode masking
  task automatic test_directed();
    steady = 1'b0;
    set_config(DATE_MID, DATE_W'(MODE_TODAY));
    send_event(10'h3FF, DATE_MID,        16'hFFFF, 1'b0, 1'b0);
    send_event(10'h000, DATE_MID,        16'h0000, 1'b1, 1'b0);
    send_event(10'd5,   DATE_MID,        16'h0100, 1'b0, 1'b0);
    send_event(10'd6,   DATE_MID,        16'h0100, 1'b1, 1'b0);
    send_event(10'd7,   DATE_MID + 1'b1, 16'h0001, 1'b0, 1'b0);
    send_event(10'd8,   DATE_MID - 1'b1, 16'h0002, 1'b0, 1'b0);
    send_event(10'd9,   DATE_MID,        16'h0100, 1'b0, 1'b1);
    // nothing kept
    send_event(10'd1,   DATE_MID + 1'b1, 16'h1234, 1'b0, 1'b0);
    send_event(10'd2,   '0,              16'h4321, 1'b1, 1'b1);
    // single kept event as the whole list
    send_event(10'd3,   DATE_MID,        16'h8000, 1'b0, 1'b1);
    drain_results();
    // overdue mode, upper data bits set to check masking
    set_config(DATE_MID, {26'h3FFFFFF, MODE_OVERDUE});
    send_event(10'd11,  '0,              16'h0042, 1'b0, 1'b0);
    send_event(10'd12,  DATE_MID - 1'b1, 16'h0001, 1'b1, 1'b0);
    send_event(10'd13,  DATE_MID,        16'h0002, 1'b0, 1'b0);
    send_event(10'd14,  DATE_MAX,        16'h0003, 1'b0, 1'b0);
    send_event(10'd15,  DATE_MID - 1'b1, 16'h0042, 1'b0, 1'b0);
    send_event(10'd16,  27'd1,           16'h0010, 1'b0, 1'b1);
    drain_results();
    // nothing can be overdue before date zero
    set_config('0, DATE_W'(MODE_OVERDUE));
    send_event(10'd17,  '0,              16'h0005, 1'b0, 1'b1);
    drain_results();
    set_config(DATE_MAX, {26'h2AAAAAA, MODE_TODAY});
    send_event(10'd18,  DATE_MAX,        16'hFFFF, 1'b0, 1'b0);
    send_event(10'd19,  DATE_MAX,        16'h0000, 1'b1, 1'b1);
    drain_results();
  endtask

  // Fill the store past capacity so later kept events are dropped and flagged
  task automatic test_overflow();
    set_config(DATE_TOP, DATE_W'(MODE_TODAY));
    steady = 1'b1;
    for (int i = 0; i < MAX_EVENTS + 3; i++) begin
      narrow_keys = ($urandom_range(0, 1) == 0);
      send_event(ID_W'($urandom), DATE_TOP,
                 narrow_keys ? KEY_W'($urandom_range(0, 15)) : KEY_W'($urandom),
                 1'($urandom_range(0, 1)), i == MAX_EVENTS + 2);
    end
    drain_results();
  endtask

  // Random lists under random settings, with a full pause part way through
  task automatic test_random(input int count);
    int goal;
    int len;
    int list_no;
    logic [DATE_W-1:0] today;
    goal = n_requests + count;
    list_no = 0;
    while (n_requests < goal) begin
      if (list_no % 3 == 2) begin
        drain_results();
        case ($urandom_range(0, 4))
          0: today = '0;
          1: today = DATE_MAX;
          2: today = DATE_TOP;
          3: today = DATE_W'($urandom);
          default: today = DATE_W'($urandom_range(0, DATE_TOP));
        endcase
        set_config(today, DATE_W'($urandom));
      end else if (list_no == 4) begin
        drain_results();
      end
      steady      = ($urandom_range(0, 3) == 0);
      narrow_keys = ($urandom_range(0, 1) == 0);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++)
        send_random(i == len - 1);
      list_no++;
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    event_id    = '0;
    event_date  = '0;
    start_time  = '0;
    is_done     = 1'b0;
    is_last     = 1'b0;
    out_ready   = 1'b0;
    ready_win   = 0;
    ready_style = 0;
    model_today = '0;
    model_mode  = MODE_TODAY;
    sorted_count = 0;
    dropped_any = 1'b0;
    burst_left  = 4;
    steady      = 1'b0;
    narrow_keys = 1'b0;
    sending     = 1'b0;
    cycles      = 0;
    errors      = 0;
    n_requests  = 0;
    n_results   = 0;
    n_lists     = 0;
    n_empty_lists = 0;
    n_ovf_lists = 0;
    n_configs   = 0;

    // Hold reset, then release at an edge
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_overflow();
    test_random(85);
    drain_results();

    $display("Covered %0d event requests in %0d lists, %0d results, %0d config settings",
             n_requests, n_lists, n_results, n_configs);
    $display("Lists with nothing kept: %0d, lists with dropped events: %0d, mismatches: %0d",
             n_empty_lists, n_ovf_lists, errors);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
